>>> rtl/core/pnmru_pkg.sv
// ----------------------------------------------------------------------------
// pnmru_pkg
// Types and constants shared by the raster sample unpacker modules.
// ----------------------------------------------------------------------------
package pnmru_pkg;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_RASTER_MODE     = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH     = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT    = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_COMPONENT_COUNT = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_PLANE_STRIDE    = 3'd4;

	localparam logic [2:0] MODE_ASCII_BITMAP  = 3'd0;
	localparam logic [2:0] MODE_PACKED_BITMAP = 3'd1;
	localparam logic [2:0] MODE_BYTE_BITMAP   = 3'd2;
	localparam logic [2:0] MODE_SAMPLE8       = 3'd3;
	localparam logic [2:0] MODE_SAMPLE16      = 3'd4;

	localparam logic [7:0] ASCII_NEWLINE = 8'h0A;
	localparam logic [7:0] ASCII_SPACE   = 8'h20;
	localparam logic [2:0] BIT_MSB       = 3'd7;
	localparam logic [2:0] BIT_LSB       = 3'd0;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		ENT_BIT    = 2'd0,
		ENT_PACKED = 2'd1,
		ENT_SAMPLE = 2'd2
	} entry_kind_t;

	typedef struct packed {
		entry_kind_t kind;
		logic [15:0] data;
	} entry_t;

	typedef struct packed {
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [2:0]  component_count;
		logic [15:0] plane_stride;
	} geom_cfg_t;

endpackage

>>> rtl/core/pnm_raster_sample_unpacker.sv
// ----------------------------------------------------------------------------
// pnm_raster_sample_unpacker
// Decodes PNM raster bytes into addressed pixel samples.
// ----------------------------------------------------------------------------
// Input channel: raw_byte is taken on a clock edge with push high and full
// low. Output channel: while empty is low the oldest sample is on the result
// ports; it is taken on a clock edge with pop high.
// Configuration: cfg_write with cfg_index selects raster_mode (0),
// image_width (1), image_height (2), component_count (3) or plane_stride (4);
// other indexes are ignored. Write only while the block is idle.
// Path: a byte's first sample is written to the work queue, then to the
// output register. Throughput: one sample per cycle, set by the single
// expansion unit, while work is queued and the output is popped or empty;
// a work entry gives one sample, a packed bitmap entry up to eight (one per
// bit, fewer when a row ends inside the byte). A four-entry work queue sits
// between intake and expansion, so intake continues while the output stalls
// until the queue fills; full then holds off further bytes.
// Reset: registers return to mode 1, all geometry 1; position counters and
// the 16-bit byte pairing clear; no sample is pending.
module pnm_raster_sample_unpacker #(
	parameter int MAX_COMPONENTS = 4,
	parameter int DIMENSION_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [pnmru_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [pnmru_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                 push,
	output logic                                 full,
	input  logic [7:0]                           raw_byte,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [15:0]                          sample_value,
	output logic [1:0]                           component_index,
	output logic [15:0]                          column_index,
	output logic [15:0]                          row_index,
	output logic [31:0]                          plane_address,
	output logic                                 last_of_byte,
	output logic                                 image_done
);
	import pnmru_pkg::*;

	logic [2:0] raster_mode_q;
	geom_cfg_t  geom_q;
	logic       q_wr;
	entry_t     q_wr_data;
	logic       q_rd;
	entry_t     q_rd_data;
	logic       q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raster_mode_q          <= MODE_PACKED_BITMAP;
			geom_q.image_width     <= 16'd1;
			geom_q.image_height    <= 16'd1;
			geom_q.component_count <= 3'd1;
			geom_q.plane_stride    <= 16'd1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_RASTER_MODE:     raster_mode_q          <= cfg_data[2:0];
				CFG_IMAGE_WIDTH:     geom_q.image_width     <= cfg_data;
				CFG_IMAGE_HEIGHT:    geom_q.image_height    <= cfg_data;
				CFG_COMPONENT_COUNT: geom_q.component_count <= cfg_data[2:0];
				CFG_PLANE_STRIDE:    geom_q.plane_stride    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	pnmru_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.raster_mode (raster_mode_q),
		.push        (push),
		.raw_byte    (raw_byte),
		.q_full      (full),
		.q_wr        (q_wr),
		.q_wr_data   (q_wr_data)
	);

	pnmru_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_wr_data),
		.full    (full),
		.rd      (q_rd),
		.rd_data (q_rd_data),
		.empty   (q_empty)
	);

	pnmru_back #(
		.MAX_COMPONENTS (MAX_COMPONENTS),
		.DIMENSION_BITS (DIMENSION_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (geom_q),
		.q_empty         (q_empty),
		.q_rd_data       (q_rd_data),
		.q_rd            (q_rd),
		.empty           (empty),
		.pop             (pop),
		.sample_value    (sample_value),
		.component_index (component_index),
		.column_index    (column_index),
		.row_index       (row_index),
		.plane_address   (plane_address),
		.last_of_byte    (last_of_byte),
		.image_done      (image_done)
	);

endmodule

>>> rtl/core/pnmru_front.sv
// ----------------------------------------------------------------------------
// pnmru_front
// Accepts raster bytes, classifies them by mode and queues work entries.
// ----------------------------------------------------------------------------
module pnmru_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [2:0]          raster_mode,
	input  logic                push,
	input  logic [7:0]          raw_byte,
	input  logic                q_full,
	output logic                q_wr,
	output pnmru_pkg::entry_t   q_wr_data
);
	import pnmru_pkg::*;

	logic       accept;
	logic [7:0] held_q;
	logic       phase_q;

	assign accept = push && !q_full;

	always_comb begin
		q_wr            = 1'b0;
		q_wr_data.kind  = ENT_SAMPLE;
		q_wr_data.data  = {8'h00, raw_byte};
		unique case (raster_mode)
			MODE_ASCII_BITMAP: begin
				q_wr           = accept && raw_byte != ASCII_NEWLINE && raw_byte != ASCII_SPACE;
				q_wr_data.kind = ENT_BIT;
				q_wr_data.data = {15'd0, ~raw_byte[0]};
			end
			MODE_PACKED_BITMAP: begin
				q_wr           = accept;
				q_wr_data.kind = ENT_PACKED;
			end
			MODE_BYTE_BITMAP: begin
				q_wr           = accept;
				q_wr_data.kind = ENT_BIT;
				q_wr_data.data = {15'd0, raw_byte[0]};
			end
			MODE_SAMPLE8: begin
				q_wr = accept;
			end
			MODE_SAMPLE16: begin
				q_wr           = accept && phase_q;
				q_wr_data.data = {held_q, raw_byte};
			end
			default: begin
				q_wr = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= 8'h00;
			phase_q <= 1'b0;
		end else if (accept && raster_mode == MODE_SAMPLE16) begin
			if (!phase_q) begin
				held_q <= raw_byte;
			end
			phase_q <= !phase_q;
		end
	end

endmodule

>>> rtl/core/pnmru_queue.sv
// ----------------------------------------------------------------------------
// pnmru_queue
// Short queue of work entries between the front and the back.
// ----------------------------------------------------------------------------
module pnmru_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  pnmru_pkg::entry_t wr_data,
	output logic              full,
	input  logic              rd,
	output pnmru_pkg::entry_t rd_data,
	output logic              empty
);
	import pnmru_pkg::*;

	entry_t               slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;
	logic                 do_wr;
	logic                 do_rd;

	assign full    = count_q == (QPTR_BITS+1)'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/pnmru_back.sv
// ----------------------------------------------------------------------------
// pnmru_back
// Expands work entries into samples, tracks the raster position and holds
// the output register.
// ----------------------------------------------------------------------------
module pnmru_back #(
	parameter int MAX_COMPONENTS = 4,
	parameter int DIMENSION_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pnmru_pkg::geom_cfg_t cfg,
	input  logic                 q_empty,
	input  pnmru_pkg::entry_t    q_rd_data,
	output logic                 q_rd,
	output logic                 empty,
	input  logic                 pop,
	output logic [15:0]          sample_value,
	output logic [1:0]           component_index,
	output logic [15:0]          column_index,
	output logic [15:0]          row_index,
	output logic [31:0]          plane_address,
	output logic                 last_of_byte,
	output logic                 image_done
);
	import pnmru_pkg::*;

	logic [DIMENSION_BITS-1:0] col_q;
	logic [DIMENSION_BITS-1:0] row_q;
	logic [1:0]                comp_q;
	logic [31:0]               base_q;
	logic [2:0]                bit_q;
	logic                      ovalid_q;

	logic                      go;
	logic                      is_packed;
	logic                      is_bitmap;
	logic [15:0]               value;
	logic [1:0]                comp_out;
	logic [2:0]                comp_eff;
	logic [2:0]                comp_inc;
	logic                      adv_pix;
	logic [DIMENSION_BITS-1:0] col_inc;
	logic [DIMENSION_BITS-1:0] row_inc;
	logic                      col_wrap;
	logic                      row_wrap;
	logic                      done;
	logic                      last;

	always_comb begin
		go        = !q_empty && (!ovalid_q || pop);
		is_packed = q_rd_data.kind == ENT_PACKED;
		is_bitmap = q_rd_data.kind != ENT_SAMPLE;
		value     = is_packed ? {15'd0, ~q_rd_data.data[bit_q]} : q_rd_data.data;
		comp_out  = is_bitmap ? 2'd0 : comp_q;
		priority if (cfg.component_count == 3'd0) begin
			comp_eff = 3'd1;
		end else if (cfg.component_count > 3'(MAX_COMPONENTS)) begin
			comp_eff = 3'(MAX_COMPONENTS);
		end else begin
			comp_eff = cfg.component_count;
		end
		comp_inc = {1'b0, comp_out} + 3'd1;
		adv_pix  = is_bitmap || comp_inc >= comp_eff;
		col_inc  = col_q + 1'b1;
		row_inc  = row_q + 1'b1;
		col_wrap = col_inc == cfg.image_width[DIMENSION_BITS-1:0];
		row_wrap = row_inc == cfg.image_height[DIMENSION_BITS-1:0];
		done     = adv_pix && col_wrap && row_wrap;
		last     = !is_packed || bit_q == BIT_LSB || col_wrap;
		q_rd     = go && last;
		empty    = !ovalid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			comp_q   <= 2'd0;
			base_q   <= 32'd0;
			bit_q    <= BIT_MSB;
			ovalid_q <= 1'b0;
		end else begin
			if (go) begin
				ovalid_q <= 1'b1;
				bit_q    <= last ? BIT_MSB : bit_q - 1'b1;
				if (adv_pix) begin
					comp_q <= 2'd0;
					if (!col_wrap) begin
						col_q <= col_inc;
					end else begin
						col_q <= '0;
						if (!row_wrap) begin
							row_q  <= row_inc;
							base_q <= base_q + 32'(cfg.plane_stride);
						end else begin
							row_q  <= '0;
							base_q <= 32'd0;
						end
					end
				end else begin
					comp_q <= comp_inc[1:0];
				end
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			sample_value    <= value;
			component_index <= comp_out;
			column_index    <= 16'(col_q);
			row_index       <= 16'(row_q);
			plane_address   <= base_q + 32'(col_q);
			last_of_byte    <= last;
			image_done      <= done;
		end
	end

`ifndef SYNTHESIS
	a_done_ends_byte: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && image_done |-> last_of_byte)
		else $error("image_done without last_of_byte");

	a_packed_holds_entry: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q != BIT_MSB |-> !q_empty && q_rd_data.kind == ENT_PACKED)
		else $error("packed expansion in progress without its entry");

	a_wrap_clears_position: assert property (@(posedge clk) disable iff (!arst_n)
		go && done |=> col_q == '0 && row_q == '0 && base_q == 32'd0)
		else $error("position not cleared after image end");
`endif

endmodule

>>> tb/pnm_raster_sample_unpacker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnm_raster_sample_unpacker_tb
// Self-checking bench for the PNM raster sample unpacker. Raster bytes go in
// through the push/full side. A local decoder tracks geometry and position
// and predicts every addressed sample. Each popped sample is compared field
// by field against the oldest prediction. Short directed tests per raster
// mode come first. Randomized phases follow, with new settings in each
// phase and random idling on both sides.
// ----------------------------------------------------------------------------
module pnm_raster_sample_unpacker_tb;

	import pnmru_pkg::*;

	localparam int MAX_COMPONENTS = 4;
	localparam int DIMENSION_BITS = 16;
	localparam int IDLE_PCT       = 11;
	localparam int RANDOM_ITEMS   = 380;
	localparam int SETTLE_CYCLES  = 48;
	localparam int DRAIN_LIMIT    = 20000;
	localparam int TIMEOUT_NS     = 3000000;

	localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED_FIRST = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED_LAST  = 3'd7;
	localparam logic [7:0] ASCII_ZERO = 8'h30;

	typedef struct packed {
		logic [15:0] value;
		logic [1:0]  comp;
		logic [15:0] col;
		logic [15:0] row;
		logic [31:0] addr;
		logic        last;
		logic        done;
	} sample_t;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      cfg_write = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
	logic                      push      = 1'b0;
	logic                      full;
	logic [7:0]                raw_byte  = '0;
	logic                      empty;
	logic                      pop       = 1'b0;
	logic [15:0]               sample_value;
	logic [1:0]                component_index;
	logic [15:0]               column_index;
	logic [15:0]               row_index;
	logic [31:0]               plane_address;
	logic                      last_of_byte;
	logic                      image_done;

	// decoder settings and position
	logic [2:0]  mode_reg       = MODE_PACKED_BITMAP;
	logic [15:0] width_reg      = 16'd1;
	logic [15:0] height_reg     = 16'd1;
	logic [2:0]  components_reg = 3'd1;
	logic [15:0] stride_reg     = 16'd1;
	logic [15:0] pos_col        = '0;
	logic [15:0] pos_row        = '0;
	logic [1:0]  pos_comp       = '0;
	logic [31:0] row_base       = '0;
	logic [7:0]  held_msb       = '0;
	logic        msb_pending    = 1'b0;

	sample_t     expected_samples[$];
	sample_t     head_sample;
	bit          full_rate        = 1'b0;
	int unsigned error_count      = 0;
	int unsigned samples_checked  = 0;
	int unsigned directed_items   = 0;
	int unsigned random_items     = 0;
	int unsigned settings_applied = 0;

	pnm_raster_sample_unpacker #(
		.MAX_COMPONENTS(MAX_COMPONENTS),
		.DIMENSION_BITS(DIMENSION_BITS)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.push           (push),
		.full           (full),
		.raw_byte       (raw_byte),
		.empty          (empty),
		.pop            (pop),
		.sample_value   (sample_value),
		.component_index(component_index),
		.column_index   (column_index),
		.row_index      (row_index),
		.plane_address  (plane_address),
		.last_of_byte   (last_of_byte),
		.image_done     (image_done)
	);

	always #5 clk = ~clk;

	function automatic logic [2:0] active_components();
		if (components_reg == 3'd0)
			return 3'd1;
		if (components_reg > MAX_COMPONENTS)
			return 3'(MAX_COMPONENTS);
		return components_reg;
	endfunction

	// advance one pixel; returns 1 when the image wraps
	function automatic logic advance_position();
		logic [15:0] next_col;
		logic [15:0] next_row;
		next_col = pos_col + 16'd1;
		if (next_col != width_reg) begin
			pos_col = next_col;
			return 1'b0;
		end
		pos_col  = '0;
		next_row = pos_row + 16'd1;
		if (next_row != height_reg) begin
			pos_row  = next_row;
			row_base = row_base + {16'd0, stride_reg};
			return 1'b0;
		end
		pos_row  = '0;
		row_base = '0;
		return 1'b1;
	endfunction

	function automatic sample_t emit_sample(input logic [15:0] value, input logic bitmap);
		sample_t    s;
		logic [2:0] next_comp;
		s.value   = value;
		s.comp    = bitmap ? 2'd0 : pos_comp;
		s.col     = pos_col;
		s.row     = pos_row;
		s.addr    = row_base + {16'd0, pos_col};
		s.last    = 1'b0;
		next_comp = {1'b0, s.comp} + 3'd1;
		if (bitmap || next_comp >= active_components()) begin
			pos_comp = '0;
			s.done   = advance_position();
		end else begin
			pos_comp = next_comp[1:0];
			s.done   = 1'b0;
		end
		return s;
	endfunction

	function automatic void decode_raster_byte(input logic [7:0] data);
		sample_t     batch[8];
		int          n;
		logic [15:0] col_before;
		logic        row_end;
		n       = 0;
		row_end = 1'b0;
		case (mode_reg)
			MODE_ASCII_BITMAP: begin
				if (data != ASCII_NEWLINE && data != ASCII_SPACE) begin
					batch[n] = emit_sample({15'd0, ~data[0]}, 1'b1);
					n++;
				end
			end
			MODE_PACKED_BITMAP: begin
				for (int i = int'(BIT_MSB); i >= int'(BIT_LSB) && !row_end; i--) begin
					col_before = pos_col;
					batch[n]   = emit_sample({15'd0, ~data[i]}, 1'b1);
					n++;
					// drop pad bits once the row ends
					row_end = (16'(col_before + 16'd1) == width_reg);
				end
			end
			MODE_BYTE_BITMAP: begin
				batch[n] = emit_sample({15'd0, data[0]}, 1'b1);
				n++;
			end
			MODE_SAMPLE8: begin
				batch[n] = emit_sample({8'd0, data}, 1'b0);
				n++;
			end
			MODE_SAMPLE16: begin
				if (!msb_pending) begin
					held_msb    = data;
					msb_pending = 1'b1;
				end else begin
					msb_pending = 1'b0;
					batch[n]    = emit_sample({held_msb, data}, 1'b0);
					n++;
				end
			end
			default: ;
		endcase
		if (n > 0)
			batch[n-1].last = 1'b1;
		for (int k = 0; k < n; k++)
			expected_samples.push_back(batch[k]);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
	                                    input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_samples.size() == 0) begin
				$error("unexpected sample: value 0x%0h column %0d row %0d",
				       sample_value, column_index, row_index);
				error_count++;
			end else begin
				head_sample = expected_samples.pop_front();
				check_field("sample_value", 32'(head_sample.value), 32'(sample_value));
				check_field("component_index", 32'(head_sample.comp),
				            32'(component_index));
				check_field("column_index", 32'(head_sample.col), 32'(column_index));
				check_field("row_index", 32'(head_sample.row), 32'(row_index));
				check_field("plane_address", head_sample.addr, plane_address);
				check_field("last_of_byte", 32'(head_sample.last), 32'(last_of_byte));
				check_field("image_done", 32'(head_sample.done), 32'(image_done));
				samples_checked++;
			end
		end
		pop <= full_rate || ($urandom_range(99) >= IDLE_PCT);
	end

	task automatic send_byte(input logic [7:0] data);
		while (!full_rate && $urandom_range(99) < IDLE_PCT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push     <= 1'b1;
		raw_byte <= data;
		do
			@(posedge clk);
		while (full);
		decode_raster_byte(data);
	endtask

	// hold off until all samples are out and the work queue has drained
	task automatic wait_idle();
		push <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
	                              input logic [CFG_DATA_BITS-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		case (index)
			CFG_RASTER_MODE:     mode_reg       = value[2:0];
			CFG_IMAGE_WIDTH:     width_reg      = value;
			CFG_IMAGE_HEIGHT:    height_reg     = value;
			CFG_COMPONENT_COUNT: components_reg = value[2:0];
			CFG_PLANE_STRIDE:    stride_reg     = value;
			default: ;
		endcase
		settings_applied++;
	endtask

	task automatic send_directed(input logic [7:0] data);
		send_byte(data);
		directed_items++;
	endtask

	task automatic set_geometry(input logic [2:0] mode, input logic [15:0] width,
	                            input logic [15:0] height, input logic [2:0] comps,
	                            input logic [15:0] stride);
		wait_idle();
		write_register(CFG_RASTER_MODE, {13'd0, mode});
		write_register(CFG_IMAGE_WIDTH, width);
		write_register(CFG_IMAGE_HEIGHT, height);
		write_register(CFG_COMPONENT_COUNT, {13'd0, comps});
		write_register(CFG_PLANE_STRIDE, stride);
	endtask

	task automatic test_reset_defaults();
		send_directed(8'h00);
		send_directed(8'hFF);
	endtask

	task automatic test_ascii_bitmap();
		set_geometry(MODE_ASCII_BITMAP, 16'd3, 16'd2, 3'd1, 16'd5);
		send_directed(ASCII_ZERO);
		send_directed(ASCII_ZERO | 8'h01);
		send_directed(ASCII_SPACE);
		send_directed(ASCII_NEWLINE);
		send_directed(ASCII_ZERO | 8'h01);
		send_directed(ASCII_ZERO);
		send_directed(8'hFF);
		send_directed(8'h00);
	endtask

	task automatic test_packed_bitmap();
		set_geometry(MODE_PACKED_BITMAP, 16'd10, 16'd2, 3'd1, 16'd16);
		send_directed(8'hA5);
		send_directed(8'h3C);
		send_directed(8'hFF);
	endtask

	task automatic test_byte_bitmap();
		set_geometry(MODE_BYTE_BITMAP, 16'd2, 16'd2, 3'd3, 16'd2);
		send_directed(8'hFE);
		send_directed(8'h01);
	endtask

	task automatic test_sample8();
		set_geometry(MODE_SAMPLE8, 16'd2, 16'd1, 3'd3, 16'd2);
		send_directed(8'h00);
		send_directed(8'hFF);
		send_directed(8'h5A);
		send_directed(8'hA5);
	endtask

	task automatic test_sample16();
		set_geometry(MODE_SAMPLE16, 16'd1, 16'd2, 3'd2, 16'd1);
		send_directed(8'hFF);
		send_directed(8'hFF);
		send_directed(8'h00);
		send_directed(8'h00);
	endtask

	task automatic test_unused_mode();
		wait_idle();
		write_register(CFG_RASTER_MODE, {13'd0, MODE_UNUSED_LAST});
		write_register(CFG_UNMAPPED_FIRST, 16'hFFFF);
		send_directed(8'h5A);
	endtask

	task automatic test_dimension_extremes();
		set_geometry(MODE_PACKED_BITMAP, 16'd1, 16'd0, 3'd0, 16'hFFFF);
		send_directed(8'hFF);
		send_directed(8'h00);
		set_geometry(MODE_BYTE_BITMAP, 16'hFFFF, 16'hFFFF, 3'd7, 16'hFFFF);
		send_directed(8'h01);
	endtask

	task automatic test_random_phases();
		int          phase;
		int          count;
		int          r;
		logic [2:0]  mode;
		logic [15:0] width;
		logic [15:0] height;
		logic [15:0] stride;
		logic [7:0]  data;
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			wait_idle();
			full_rate = (phase == 4 || phase == 5);
			if ($urandom_range(99) < 8)
				mode = 3'($urandom_range(MODE_UNUSED_LAST, MODE_UNUSED_FIRST));
			else
				mode = 3'($urandom_range(MODE_SAMPLE16, MODE_ASCII_BITMAP));
			r = $urandom_range(99);
			if (r < 80)
				width = 16'($urandom_range(12, 1));
			else if (r < 90)
				width = 16'($urandom_range(300, 13));
			else
				width = (r < 95) ? 16'd0 : 16'hFFFF;
			r = $urandom_range(99);
			if (r < 80)
				height = 16'($urandom_range(6, 1));
			else if (r < 90)
				height = 16'($urandom_range(40, 7));
			else
				height = (r < 95) ? 16'd0 : 16'hFFFF;
			r = $urandom_range(99);
			if (r < 70)
				stride = width + 16'($urandom_range(7, 0));
			else
				stride = (r < 85) ? 16'hFFFF : 16'($urandom);
			write_register(CFG_RASTER_MODE, {13'd0, mode});
			write_register(CFG_IMAGE_WIDTH, width);
			write_register(CFG_IMAGE_HEIGHT, height);
			write_register(CFG_COMPONENT_COUNT, 16'($urandom_range(7, 0)));
			write_register(CFG_PLANE_STRIDE, stride);
			if ($urandom_range(99) < 10)
				write_register(CFG_INDEX_BITS'($urandom_range(CFG_UNMAPPED_LAST,
				               CFG_UNMAPPED_FIRST)), 16'($urandom));
			count = (mode > MODE_SAMPLE16) ? $urandom_range(4, 2) : $urandom_range(48, 12);
			for (int k = 0; k < count; k++) begin
				r = $urandom_range(99);
				if (mode == MODE_ASCII_BITMAP && r < 25)
					data = r[0] ? ASCII_SPACE : ASCII_NEWLINE;
				else if (mode == MODE_ASCII_BITMAP && r < 60)
					data = ASCII_ZERO | {7'd0, r[0]};
				else if (r >= 90)
					data = r[0] ? 8'hFF : 8'h00;
				else
					data = 8'($urandom);
				send_byte(data);
				random_items++;
			end
			phase++;
		end
		full_rate = 1'b0;
	endtask

	initial begin : main
		int waited;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_defaults();
		test_ascii_bitmap();
		test_packed_bitmap();
		test_byte_bitmap();
		test_sample8();
		test_sample16();
		test_unused_mode();
		test_dimension_extremes();
		test_random_phases();

		push   <= 1'b0;
		waited = 0;
		while (expected_samples.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_samples.size() != 0) begin
			$error("%0d expected samples never arrived", expected_samples.size());
			error_count++;
		end

		$display("Sent %0d directed and %0d random raster bytes under %0d register writes",
		         directed_items, random_items, settings_applied);
		$display("Checked %0d samples across all five raster modes, %0d mismatches",
		         samples_checked, error_count);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> pnm_raster_sample_unpacker.f
rtl/core/pnmru_pkg.sv
rtl/core/pnmru_front.sv
rtl/core/pnmru_queue.sv
rtl/core/pnmru_back.sv
rtl/core/pnm_raster_sample_unpacker.sv
tb/pnm_raster_sample_unpacker_tb.sv
